[rtl/ite_pkg.sv]
// Shared codes and types for the infix token evaluator.
// Token kinds, status codes, operator kinds and the controller/datapath interface.
// No dependencies.
`default_nettype none

package ite_pkg;

  localparam logic [2:0] TK_NUMBER = 3'd0;
  localparam logic [2:0] TK_PLUS   = 3'd1;
  localparam logic [2:0] TK_MINUS  = 3'd2;
  localparam logic [2:0] TK_TIMES  = 3'd3;
  localparam logic [2:0] TK_DIVIDE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_TIMES  = 2'd1;
  localparam logic [1:0] MK_DIVIDE = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_NUM_LOAD,
    OP_ARITH_START,
    OP_ARITH_STEP,
    OP_ARITH_COMMIT,
    OP_ADD_OP,
    OP_MUL_OP,
    OP_ERROR,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic       expect_number;
    logic [1:0] mul_kind;
    logic       err_any;
    logic       value_zero;
    logic       step_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/ite_datapath.sv]
// Datapath of the infix token evaluator: expression registers, shared
// shift-add multiplier / restoring divider and the result register.
// Depends on ite_pkg.
`default_nettype none

module ite_datapath #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ite_pkg::dp_cmd_t    cmd,
  input  logic [2:0]          token_kind,
  input  logic signed [31:0]  operand_value,
  output ite_pkg::dp_status_t status,
  output logic signed [31:0]  expression_value,
  output logic [1:0]          eval_status
);
  import ite_pkg::*;

  localparam int CW = $clog2(WORD_WIDTH);

  logic [WORD_WIDTH-1:0] running_sum;
  logic [WORD_WIDTH-1:0] current_term;
  logic                  pending_add_is_minus;
  logic [1:0]            pending_mul_kind;
  logic                  expect_number;
  logic [1:0]            error_code;

  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] x;
  logic [WORD_WIDTH-1:0] y;
  logic                  neg_q;
  logic [CW-1:0]         cnt;

  logic [WORD_WIDTH-1:0] val_w;
  logic [WORD_WIDTH-1:0] sum_fold;
  logic [WORD_WIDTH-1:0] mag_term;
  logic [WORD_WIDTH-1:0] mag_val;
  logic [WORD_WIDTH:0]   rem_shift;
  logic [WORD_WIDTH:0]   diff;
  logic                  is_div;
  logic [1:0]            final_code;

  always_comb begin
    val_w     = WORD_WIDTH'(operand_value);
    sum_fold  = pending_add_is_minus ? running_sum - current_term : running_sum + current_term;
    mag_term  = current_term[WORD_WIDTH-1] ? -current_term : current_term;
    mag_val   = val_w[WORD_WIDTH-1] ? -val_w : val_w;
    rem_shift = {acc, x[WORD_WIDTH-1]};
    diff      = rem_shift - {1'b0, y};
    is_div    = (pending_mul_kind == MK_DIVIDE);
    if (error_code != ST_OK) begin
      final_code = error_code;
    end else if (expect_number) begin
      final_code = ST_MALFORMED;
    end else begin
      final_code = ST_OK;
    end
  end

  assign status.expect_number = expect_number;
  assign status.mul_kind      = pending_mul_kind;
  assign status.err_any       = (error_code != ST_OK);
  assign status.value_zero    = (val_w == '0);
  assign status.step_last     = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum          <= '0;
      current_term         <= '0;
      pending_add_is_minus <= 1'b0;
      pending_mul_kind     <= MK_NONE;
      expect_number        <= 1'b1;
      error_code           <= ST_OK;
      cnt                  <= CW'(WORD_WIDTH - 1);
    end else begin
      unique case (cmd.op)
        OP_NUM_LOAD: begin
          current_term     <= val_w;
          pending_mul_kind <= MK_NONE;
          expect_number    <= 1'b0;
        end
        OP_ARITH_START: begin
          acc   <= '0;
          x     <= is_div ? mag_term : current_term;
          y     <= is_div ? mag_val : val_w;
          neg_q <= current_term[WORD_WIDTH-1] ^ val_w[WORD_WIDTH-1];
          cnt   <= CW'(WORD_WIDTH - 1);
        end
        OP_ARITH_STEP: begin
          if (is_div) begin
            if (!diff[WORD_WIDTH]) begin
              acc <= diff[WORD_WIDTH-1:0];
              x   <= {x[WORD_WIDTH-2:0], 1'b1};
            end else begin
              acc <= rem_shift[WORD_WIDTH-1:0];
              x   <= {x[WORD_WIDTH-2:0], 1'b0};
            end
          end else begin
            if (y[0]) begin
              acc <= acc + x;
            end
            x <= {x[WORD_WIDTH-2:0], 1'b0};
            y <= {1'b0, y[WORD_WIDTH-1:1]};
          end
          cnt <= cnt - 1'b1;
        end
        OP_ARITH_COMMIT: begin
          current_term     <= is_div ? (neg_q ? -x : x) : acc;
          pending_mul_kind <= MK_NONE;
          expect_number    <= 1'b0;
        end
        OP_ADD_OP: begin
          running_sum          <= sum_fold;
          current_term         <= '0;
          pending_add_is_minus <= (token_kind == TK_MINUS);
          expect_number        <= 1'b1;
        end
        OP_MUL_OP: begin
          pending_mul_kind <= (token_kind == TK_TIMES) ? MK_TIMES : MK_DIVIDE;
          expect_number    <= 1'b1;
        end
        OP_ERROR: begin
          if (error_code == ST_OK) begin
            error_code <= cmd.err;
          end
        end
        OP_FINISH: begin
          eval_status          <= final_code;
          expression_value     <= (final_code == ST_OK) ? 32'($signed(sum_fold)) : '0;
          running_sum          <= '0;
          current_term         <= '0;
          pending_add_is_minus <= 1'b0;
          pending_mul_kind     <= MK_NONE;
          expect_number        <= 1'b1;
          error_code           <= ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ite_controller.sv]
// Controller of the infix token evaluator: token decode, sequencing of the
// shared arithmetic unit and the input/output handshakes. Depends on ite_pkg.
`default_nettype none

module ite_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          token_kind,
  input  logic                last_token,
  output logic                out_valid,
  input  logic                out_ready,
  input  ite_pkg::dp_status_t status,
  output ite_pkg::dp_cmd_t    cmd
);
  import ite_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARITH,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_q;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op     = OP_NONE;
    cmd.err    = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!status.err_any) begin
            priority case (token_kind)
              TK_NUMBER: begin
                if (status.expect_number == 1'b0) begin
                  cmd.op  = OP_ERROR;
                  cmd.err = ST_MALFORMED;
                end else if (status.mul_kind == MK_TIMES) begin
                  cmd.op = OP_ARITH_START;
                end else if (status.mul_kind == MK_DIVIDE) begin
                  if (status.value_zero) begin
                    cmd.op  = OP_ERROR;
                    cmd.err = ST_DIV_ZERO;
                  end else begin
                    cmd.op = OP_ARITH_START;
                  end
                end else begin
                  cmd.op = OP_NUM_LOAD;
                end
              end
              TK_PLUS, TK_MINUS: begin
                if (status.expect_number) begin
                  cmd.op  = OP_ERROR;
                  cmd.err = ST_MALFORMED;
                end else begin
                  cmd.op = OP_ADD_OP;
                end
              end
              TK_TIMES, TK_DIVIDE: begin
                if (status.expect_number) begin
                  cmd.op  = OP_ERROR;
                  cmd.err = ST_MALFORMED;
                end else begin
                  cmd.op = OP_MUL_OP;
                end
              end
              default: begin
                cmd.op  = OP_ERROR;
                cmd.err = ST_MALFORMED;
              end
            endcase
          end
          if (cmd.op == OP_ARITH_START) begin
            state_next = S_ARITH;
          end else if (last_token) begin
            state_next = S_FINISH;
          end
        end
      end
      S_ARITH: begin
        cmd.op = OP_ARITH_STEP;
        if (status.step_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op     = OP_ARITH_COMMIT;
        state_next = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        last_q <= last_token;
      end
      if (cmd.op == OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/infix_token_evaluator.sv]
// Infix token evaluator with two precedence levels: a token a transaction,
// one result transaction per expression. An operator, a plain number, a token
// out of order or an ignored token after an error is handled in the idle state.
// A number that follows * or / (other than a zero divisor) goes through a load
// step, the bit steps of the shared shift-add multiplier / restoring divider,
// which retires one bit a cycle, and a commit step; no token is taken meanwhile.
// The last token of an expression then passes a finish step that loads the
// result register, and waits there while a previous result is still not taken.
// Arithmetic wraps at WORD_WIDTH bits; division truncates toward zero.
// Depends on ite_pkg, ite_controller and ite_datapath.
`default_nettype none

module infix_token_evaluator #(
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         token_kind,
  input  logic signed [31:0] operand_value,
  input  logic               last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] expression_value,
  output logic [1:0]         eval_status
);
  import ite_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ite_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .token_kind (token_kind),
    .last_token (last_token),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  ite_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .token_kind       (token_kind),
    .operand_value    (operand_value),
    .status           (status),
    .expression_value (expression_value),
    .eval_status      (eval_status)
  );

endmodule

`default_nettype wire

[rtl/ite_checker.sv]
// Port-level checks for the infix token evaluator, bound to its top level.
// Depends on infix_token_evaluator and ite_pkg.
`default_nettype none

module ite_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last_token,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] expression_value,
  input logic [1:0]         eval_status
);
  import ite_pkg::*;

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(expression_value) && $stable(eval_status))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && eval_status != ST_OK |-> expression_value == '0)
    else $error("error result carries a value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> eval_status == ST_OK || eval_status == ST_DIV_ZERO ||
                  eval_status == ST_MALFORMED)
    else $error("undefined status code");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_token && !out_valid |=> !out_valid)
    else $error("result without a last token");

endmodule

bind infix_token_evaluator ite_checker u_ite_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .last_token       (last_token),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .expression_value (expression_value),
  .eval_status      (eval_status)
);

`default_nettype wire
